// ===== hw/rtl/fri_pkg.sv =====
`default_nettype none

package fri_pkg;

    // Instruction kinds carried in the operation field. Codes 11 to 15 are
    // undefined and behave as a plain counter increment.
    typedef enum logic [3:0] {
        OP_INC      = 4'd0,
        OP_DEC      = 4'd1,
        OP_CPY_REG  = 4'd2,
        OP_CPY_IMM  = 4'd3,
        OP_JNZ_II   = 4'd4,
        OP_JNZ_IR   = 4'd5,
        OP_JNZ_RI   = 4'd6,
        OP_JNZ_RR   = 4'd7,
        OP_OUT_IMM  = 4'd8,
        OP_OUT_REG  = 4'd9,
        OP_RESTART  = 4'd10
    } t_op;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned OPND_W   = 32;
    localparam int unsigned PLEN_W   = 16;
    localparam int unsigned NEXTPC_W = 16;

    typedef struct packed {
        logic        [3:0]        operation;
        logic signed [OPND_W-1:0] first_operand;
        logic signed [OPND_W-1:0] second_operand;
    } t_in_item;

    typedef struct packed {
        logic        [NEXTPC_W-1:0] next_pc;
        logic                       halted;
        logic                       out_valid;
        logic signed [DATA_W-1:0]   out_value;
    } t_out_item;

    // Sign-extend a 32-bit operand to the register width.
    function automatic logic [DATA_W-1:0] sext_opnd(input logic [OPND_W-1:0] v);
        return {{(DATA_W-OPND_W){v[OPND_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/four_register_instruction_executor_unit.sv =====
// Path: an accepted instruction waits in the input register, executes, and its
// result is offered from the result register until it is taken.
// Throughput: one instruction per cycle while results are taken; execute is a
// register file update plus one 64-bit counter add and limit compare.
// Reset (synchronous, active low) clears the registers, counter, halt bit,
// program length and both pipeline valid flags.
`default_nettype none

module four_register_instruction_executor_unit
    import fri_pkg::*;
#(
    parameter int unsigned PC_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [PLEN_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data
);

    // Input register: holds one accepted instruction until it executes.
    logic      r_in_valid;
    t_in_item  r_in;

    // Result register: holds one finished result until it is taken.
    logic      r_out_valid;
    t_out_item r_out;

    logic      exec_fire;
    t_out_item exec_result;

    // The instruction in the input register executes whenever the result
    // register is empty or is being emptied in this same cycle. Machine state
    // is committed on that edge, so the next instruction sees it at once.
    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);

    // A new transaction can enter whenever the input register is free or is
    // moving on into the result register in this cycle.
    assign o_in_ready = !r_in_valid || exec_fire;

    fri_core #(
        .PC_WIDTH (PC_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (exec_fire),
        .i_item     (r_in),
        .o_result   (exec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset; they load under the same conditions.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (exec_fire) begin
            r_out <= exec_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/fri_core.sv =====
`default_nettype none

module fri_core
    import fri_pkg::*;
#(
    parameter int unsigned PC_WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [PLEN_W-1:0]    i_cfg_data,
    input  wire logic                 i_fire,
    input  wire t_in_item             i_item,
    output t_out_item                 o_result
);

    logic [DATA_W-1:0]   r_reg_a, r_reg_b, r_reg_c, r_reg_d;
    logic [DATA_W-1:0]   n_reg_a, n_reg_b, n_reg_c, n_reg_d;
    logic [PC_WIDTH-1:0] r_pc, n_pc;
    logic                r_halt, n_halt;
    logic [PLEN_W-1:0]   r_plen;

    logic [DATA_W-1:0] pc_ext, limit, cap, plen_ext;
    logic [DATA_W-1:0] a1, a2, src1, src2, target, offset;
    logic [DATA_W-1:0] wr_data;
    logic [1:0]        wr_idx;
    logic              wr_en, take;
    logic              emit;
    logic [DATA_W-1:0] emit_value;
    t_op               op;

    function automatic logic [DATA_W-1:0] rd_sel(
        input logic [1:0]        idx,
        input logic [DATA_W-1:0] ra, rb, rc, rd
    );
        logic [DATA_W-1:0] v;
        case (idx)
            2'd0:    v = ra;
            2'd1:    v = rb;
            2'd2:    v = rc;
            default: v = rd;
        endcase
        return v;
    endfunction

    // The usable program length is capped at the size of the counter space.
    assign cap      = DATA_W'(1) << PC_WIDTH;
    assign plen_ext = DATA_W'(r_plen);
    assign limit    = (plen_ext > cap) ? cap : plen_ext;

    assign pc_ext = DATA_W'(r_pc);
    assign a1     = sext_opnd(i_item.first_operand);
    assign a2     = sext_opnd(i_item.second_operand);
    assign src1   = rd_sel(i_item.first_operand[1:0], r_reg_a, r_reg_b, r_reg_c, r_reg_d);
    assign src2   = rd_sel(i_item.second_operand[1:0], r_reg_a, r_reg_b, r_reg_c, r_reg_d);
    assign op     = t_op'(i_item.operation);

    // Decode: register write, jump decision and output value.
    always_comb begin
        wr_en      = 1'b0;
        wr_idx     = i_item.first_operand[1:0];
        wr_data    = '0;
        take       = 1'b0;
        offset     = a2;
        emit       = 1'b0;
        emit_value = '0;
        unique case (op)
            OP_INC: begin
                wr_en   = 1'b1;
                wr_data = src1 + DATA_W'(1);
            end
            OP_DEC: begin
                wr_en   = 1'b1;
                wr_data = src1 - DATA_W'(1);
            end
            OP_CPY_REG: begin
                wr_en   = 1'b1;
                wr_idx  = i_item.second_operand[1:0];
                wr_data = src1;
            end
            OP_CPY_IMM: begin
                wr_en   = 1'b1;
                wr_idx  = i_item.second_operand[1:0];
                wr_data = a1;
            end
            OP_JNZ_II: begin
                take = (a1 != '0);
            end
            OP_JNZ_IR: begin
                take   = (a1 != '0);
                offset = src2;
            end
            OP_JNZ_RI: begin
                take = (src1 != '0);
            end
            OP_JNZ_RR: begin
                take   = (src1 != '0);
                offset = src2;
            end
            OP_OUT_IMM: begin
                emit       = 1'b1;
                emit_value = a1;
            end
            OP_OUT_REG: begin
                emit       = 1'b1;
                emit_value = src1;
            end
            default: ;
        endcase
    end

    assign target = take ? (pc_ext + offset) : (pc_ext + DATA_W'(1));

    // State update and result, with restart and halted machine overriding.
    always_comb begin
        n_reg_a = r_reg_a;
        n_reg_b = r_reg_b;
        n_reg_c = r_reg_c;
        n_reg_d = r_reg_d;
        n_pc    = r_pc;
        n_halt  = r_halt;
        o_result.next_pc   = NEXTPC_W'(pc_ext);
        o_result.halted    = 1'b1;
        o_result.out_valid = 1'b0;
        o_result.out_value = '0;
        if (op == OP_RESTART) begin
            n_reg_a = a1;
            n_reg_b = '0;
            n_reg_c = '0;
            n_reg_d = '0;
            n_pc    = '0;
            n_halt  = (limit == '0);
            o_result.next_pc = '0;
            o_result.halted  = n_halt;
        end else if (r_halt || (pc_ext >= limit)) begin
            n_halt = 1'b1;
        end else begin
            if (wr_en) begin
                case (wr_idx)
                    2'd0:    n_reg_a = wr_data;
                    2'd1:    n_reg_b = wr_data;
                    2'd2:    n_reg_c = wr_data;
                    default: n_reg_d = wr_data;
                endcase
            end
            n_halt = (target >= limit);
            n_pc   = target[PC_WIDTH-1:0];
            o_result.next_pc   = NEXTPC_W'(DATA_W'(n_pc));
            o_result.halted    = n_halt;
            o_result.out_valid = emit;
            o_result.out_value = emit_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_a <= '0;
            r_reg_b <= '0;
            r_reg_c <= '0;
            r_reg_d <= '0;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            r_plen  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_plen <= i_cfg_data;
            end
            if (i_fire) begin
                r_reg_a <= n_reg_a;
                r_reg_b <= n_reg_b;
                r_reg_c <= n_reg_c;
                r_reg_d <= n_reg_d;
                r_pc    <= n_pc;
                r_halt  <= n_halt;
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_four_register_instruction_executor_unit.sv =====
`default_nettype none

module tb_four_register_instruction_executor_unit
    import fri_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned PHASE_ITEMS   = 191;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned HOLD_PHASE    = 2;
    localparam int unsigned PAUSE_PHASE   = 5;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // Register indexes as seen in the operand fields (only the low two bits matter).
    localparam logic [31:0] REG_A = 32'd0;
    localparam logic [31:0] REG_B = 32'd1;
    localparam logic [31:0] REG_C = 32'd2;
    localparam logic [31:0] REG_D = 32'd3;

    // Operation codes with no defined meaning; they only advance the counter.
    localparam logic [3:0] OP_UNDEF_FIRST = 4'd11;
    localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;

    // Tracks the architectural state of the machine and holds the results that
    // the block still owes, oldest first.
    class machine_tracker;
        logic [63:0] regs [4];
        logic [15:0] pc;
        bit          stopped;
        logic [15:0] plen;
        t_out_item   owed_results [$];
        int unsigned mismatches;
        int unsigned executed;
        int unsigned emitted;
        int unsigned restarts;
        int unsigned halted_results;

        function new();
            foreach (regs[i]) regs[i] = '0;
            pc = '0;
            stopped = 1'b0;
            plen = '0;
            mismatches = 0;
            executed = 0;
            emitted = 0;
            restarts = 0;
            halted_results = 0;
        endfunction

        function void set_length(logic [15:0] v);
            plen = v;
        endfunction

        // True when the next instruction other than a restart will be ignored.
        function bit is_stopped();
            return stopped || (pc >= plen);
        endfunction

        // Executes one instruction on the tracked state and returns its result.
        function t_out_item execute(t_in_item it);
            logic [63:0] a1;
            logic [63:0] a2;
            logic [63:0] target;
            logic [63:0] value;
            int          r1;
            int          r2;
            bit          emit;
            t_out_item   res;
            a1 = {{32{it.first_operand[31]}}, it.first_operand};
            a2 = {{32{it.second_operand[31]}}, it.second_operand};
            r1 = int'(a1[1:0]);
            r2 = int'(a2[1:0]);
            target = {48'd0, pc} + 64'd1;
            emit = 1'b0;
            value = '0;
            res.out_valid = 1'b0;
            res.out_value = '0;

            if (it.operation == OP_RESTART) begin
                foreach (regs[i]) regs[i] = '0;
                regs[0] = a1;
                pc = '0;
                stopped = (plen == 16'd0);
                restarts++;
                res.next_pc = '0;
                res.halted = stopped;
                return res;
            end

            // A halted machine ignores everything but a restart.
            if (is_stopped()) begin
                stopped = 1'b1;
                res.next_pc = pc;
                res.halted = 1'b1;
                return res;
            end

            executed++;
            case (it.operation)
                OP_INC: begin
                    regs[r1] = regs[r1] + 64'd1;
                end
                OP_DEC: begin
                    regs[r1] = regs[r1] - 64'd1;
                end
                OP_CPY_REG: begin
                    regs[r2] = regs[r1];
                end
                OP_CPY_IMM: begin
                    regs[r2] = a1;
                end
                OP_JNZ_II: begin
                    if (a1 != 0) target = {48'd0, pc} + a2;
                end
                OP_JNZ_IR: begin
                    if (a1 != 0) target = {48'd0, pc} + regs[r2];
                end
                OP_JNZ_RI: begin
                    if (regs[r1] != 0) target = {48'd0, pc} + a2;
                end
                OP_JNZ_RR: begin
                    if (regs[r1] != 0) target = {48'd0, pc} + regs[r2];
                end
                OP_OUT_IMM: begin
                    emit = 1'b1;
                    value = a1;
                end
                OP_OUT_REG: begin
                    emit = 1'b1;
                    value = regs[r1];
                end
                default: begin
                end
            endcase

            // A negative target wraps to a huge unsigned value and halts too.
            stopped = (target >= {48'd0, plen});
            pc = target[15:0];
            if (emit) emitted++;
            res.next_pc = pc;
            res.halted = stopped;
            res.out_valid = emit;
            res.out_value = value;
            return res;
        endfunction

        function void note_instruction(t_in_item it);
            owed_results = {owed_results, execute(it)};
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_results.size() == 0) begin
                $error("unexpected result transaction: next_pc %0d halted %0b",
                       got.next_pc, got.halted);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.halted === 1'b1) halted_results++;
            if (got.next_pc !== want.next_pc) begin
                $error("next_pc: expected %0d, actual %0d", want.next_pc, got.next_pc);
                mismatches++;
            end
            if (got.halted !== want.halted) begin
                $error("halted: expected %0b, actual %0b", want.halted, got.halted);
                mismatches++;
            end
            if (got.out_valid !== want.out_valid) begin
                $error("out_valid: expected %0b, actual %0b", want.out_valid, got.out_valid);
                mismatches++;
            end
            if (got.out_value !== want.out_value) begin
                $error("out_value: expected %0h, actual %0h", want.out_value, got.out_value);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [PLEN_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b1;
    t_out_item         o_out_data;

    machine_tracker tracker = new();
    bit             hold_off_request = 1'b0;
    int unsigned    cycle_count = 0;
    int unsigned    lengths_used = 0;

    four_register_instruction_executor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Every accepted result transaction is checked against the oldest owed one.
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready) tracker.check_result(o_out_data);
    end

    // The receiver runs in segments, each with its own stall rate, from never
    // stalling to stalling most cycles. On request it holds off for a long
    // stretch so the pipeline backs up into the input side.
    initial begin
        int unsigned seg_len;
        int unsigned stall_pct;
        forever begin
            seg_len = $urandom_range(10, 60);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (seg_len) begin
                @(posedge i_clk);
                if (hold_off_request) begin
                    hold_off_request = 1'b0;
                    i_out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic t_in_item make_item(logic [3:0] op, logic [31:0] first,
                                           logic [31:0] second);
        t_in_item it;
        it.operation = op;
        it.first_operand = first;
        it.second_operand = second;
        return it;
    endfunction

    // Register index: mostly plain, sometimes with junk in the upper bits.
    function automatic logic [31:0] pick_index();
        if ($urandom_range(0, 99) < 70) return 32'($urandom_range(0, 3));
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_immediate();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 32'($urandom_range(0, 16)) - 32'd8;
        if (roll < 85) return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Jump offset that mostly lands inside the program so runs keep going.
    function automatic logic [31:0] pick_offset();
        logic [15:0] dest;
        if (tracker.plen != 0 && $urandom_range(0, 99) < 80) begin
            dest = 16'($urandom_range(0, tracker.plen - 1));
            return {16'd0, dest} - {16'd0, tracker.pc};
        end
        return pick_immediate();
    endfunction

    // Builds the next random instruction from the current machine state: a
    // halted machine is usually restarted, a running one gets program-like code.
    function automatic t_in_item random_instruction();
        int unsigned roll;
        logic [3:0]  op;
        logic [31:0] cond;
        roll = $urandom_range(0, 99);
        if (tracker.is_stopped() && roll < 75) op = OP_RESTART;
        else if (roll < 4) op = OP_RESTART;
        else if (roll < 7) op = 4'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        else op = 4'($urandom_range(OP_INC, OP_OUT_REG));
        cond = ($urandom_range(0, 99) < 80) ? (pick_immediate() | 32'd1) : 32'd0;
        case (op) inside
            OP_INC, OP_DEC, OP_OUT_REG: begin
                return make_item(op, pick_index(), $urandom());
            end
            OP_CPY_REG:  return make_item(op, pick_index(), pick_index());
            OP_CPY_IMM:  return make_item(op, pick_immediate(), pick_index());
            OP_JNZ_II:   return make_item(op, cond, pick_offset());
            OP_JNZ_IR:   return make_item(op, cond, pick_index());
            OP_JNZ_RI:   return make_item(op, pick_index(), pick_offset());
            OP_JNZ_RR:   return make_item(op, pick_index(), pick_index());
            default:     return make_item(op, pick_immediate(), $urandom());
        endcase
    endfunction

    // Offers one instruction and waits for the transaction. Valid stays high on
    // return so back-to-back transactions need no extra assignment.
    task automatic send_item(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.note_instruction(it);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
    endtask

    // The length register is only written with the pipeline empty.
    task automatic write_program_length(logic [15:0] len);
        wait_for_drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_length(len);
        lengths_used++;
    endtask

    initial begin
        int unsigned lengths [NUM_PHASES];
        int unsigned burst_left;
        int unsigned gap;
        bit          busy_burst;

        lengths = '{1, 2, 100, 65535, 0, 37, 0, 12};
        lengths[6] = $urandom_range(3, 600);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Right after reset the program is empty, so even a
        // restart leaves the machine halted and the next instruction is ignored.
        send_item(make_item(OP_RESTART, 32'd5, 32'd0));
        send_item(make_item(OP_INC, REG_A, 32'd0));
        write_program_length(16'd64);

        // Restart with both extremes of the value loaded into register a.
        send_item(make_item(OP_RESTART, 32'h7FFF_FFFF, 32'd0));
        send_item(make_item(OP_RESTART, 32'h8000_0000, 32'd0));
        // Index fields with upper bits set still pick by their low two bits.
        send_item(make_item(OP_INC, 32'hFFFF_FFFC, 32'd0));
        send_item(make_item(OP_DEC, REG_B, 32'd0));
        send_item(make_item(OP_CPY_REG, REG_B, 32'h8000_0002));
        send_item(make_item(OP_CPY_IMM, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(OP_OUT_IMM, 32'h8000_0000, 32'd0));
        send_item(make_item(OP_OUT_REG, 32'hFFFF_FFFE, 32'd0));
        // Not taken, taken forward, then taken backward off a register.
        send_item(make_item(OP_JNZ_II, 32'd0, 32'd9));
        send_item(make_item(OP_JNZ_II, 32'hFFFF_FFFF, 32'd2));
        send_item(make_item(OP_JNZ_RI, REG_C, 32'hFFFF_FFFD));
        send_item(make_item(OP_CPY_IMM, 32'd2, REG_B));
        send_item(make_item(OP_JNZ_IR, 32'd1, REG_B));
        send_item(make_item(OP_JNZ_RR, REG_A, REG_B));
        send_item(make_item(OP_UNDEF_FIRST, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(OP_UNDEF_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Land on the last instruction, then step off the end of the program.
        send_item(make_item(OP_JNZ_II, 32'd1, 32'd63 - {16'd0, tracker.pc}));
        send_item(make_item(OP_INC, REG_D, 32'd0));
        send_item(make_item(OP_OUT_IMM, 32'd7, 32'd0));
        // A jump to a negative target halts as well.
        send_item(make_item(OP_RESTART, 32'd0, 32'd0));
        send_item(make_item(OP_JNZ_II, 32'd1, 32'h8000_0000));
        send_item(make_item(OP_RESTART, 32'hFFFF_FFFF, 32'd0));

        // Random part: one phase per program length, each opened by a restart.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_program_length(16'(lengths[p]));
            send_item(make_item(OP_RESTART, pick_immediate(), $urandom()));
            burst_left = $urandom_range(1, 30);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while the sender keeps offering work.
                if (p == HOLD_PHASE && n == 20) hold_off_request = 1'b1;
                busy_burst = (p == HOLD_PHASE && n >= 20 && n < 120);
                // Sender pause until every owed result has come back.
                if (p == PAUSE_PHASE && n == 100) wait_for_drain();
                send_item(random_instruction());
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap != 0 && !busy_burst) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d instructions and %0d restarts over %0d program lengths.",
                 tracker.executed, tracker.restarts, lengths_used);
        $display("Saw %0d output values and %0d halted results.",
                 tracker.emitted, tracker.halted_results);
        if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
